// File: sv/kumst_pkg.sv
// ----------------------------------------------------------------------------
// kumst_pkg
// Shared widths and constants of the union-find spanning tree accumulator.
// ----------------------------------------------------------------------------
package kumst_pkg;

	localparam int NODE_W   = 10;
	localparam int WEIGHT_W = 16;
	localparam int TOTAL_W  = 26;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef logic [NODE_W-1:0]   node_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [TOTAL_W-1:0]  total_t;

endpackage

// File: sv/kumst_edge_if.sv
// ----------------------------------------------------------------------------
// kumst_edge_if
// Valid/ready channel that carries one graph edge per beat.
// ----------------------------------------------------------------------------
interface kumst_edge_if;

	logic              valid;
	logic              ready;
	kumst_pkg::node_t   node_a;
	kumst_pkg::node_t   node_b;
	kumst_pkg::weight_t weight;

	modport source (output valid, output node_a, output node_b, output weight, input ready);
	modport sink   (input valid, input node_a, input node_b, input weight, output ready);

endinterface

// File: sv/kumst_result_if.sv
// ----------------------------------------------------------------------------
// kumst_result_if
// Valid/ready channel that carries one edge verdict and running total per beat.
// ----------------------------------------------------------------------------
interface kumst_result_if;

	logic             valid;
	logic             ready;
	logic             accepted;
	kumst_pkg::total_t tree_weight;

	modport source (output valid, output accepted, output tree_weight, input ready);
	modport sink   (input valid, input accepted, input tree_weight, output ready);

endinterface

// File: sv/kumst_parent_ram.sv
// ----------------------------------------------------------------------------
// kumst_parent_ram
// Parent table memory, one write and one registered read port, with a
// clearing sweep after reset that makes every entry its own parent.
// ----------------------------------------------------------------------------
module kumst_parent_ram #(
	parameter int NODES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic we,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] waddr,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] wdata,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] raddr,
	output logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] rdata,
	output logic ready
);

	localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NODES - 1);

	logic [IDX_W-1:0] mem [NODES];
	logic [IDX_W-1:0] clr_q;
	logic             clearing_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = clr_q;
		end else begin
			mem_we    = we;
			mem_waddr = waddr;
			mem_wdata = wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata <= mem[raddr];
	end

	assign ready = !clearing_q;

endmodule

// File: sv/kruskal_union_find_mst.sv
// node_a is walked to its root and its path compressed, then node_b likewise, and the
//   result is loaded; an edge with a node out of range goes straight to the result.
//   one edge at a time, each hop is one parent table read.
// the next edge is taken while a result waits, but not while an edge is still in work.
// reset: asynchronous, active low; a clearing sweep then sets every
//   parent entry to its own index, and no edge is taken until it ends.
// ----------------------------------------------------------------------------
// kruskal_union_find_mst
// Kruskal spanning tree accumulator over a union-find forest with path
// compression, the forest held in one synchronous memory.
// ----------------------------------------------------------------------------
module kruskal_union_find_mst #(
	parameter int NODES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	kumst_edge_if.sink     edge_in,
	kumst_result_if.source result
);

	localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [17:0] NODES_L = 18'(NODES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_COMP = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]         state_q;
	logic               phase_b_q;
	logic [IDX_W-1:0]   cur_q;
	logic [IDX_W-1:0]   start_q;
	logic [IDX_W-1:0]   x_q;
	logic [IDX_W-1:0]   root_q;
	logic [IDX_W-1:0]   root_a_q;
	logic [IDX_W-1:0]   node_b_q;
	kumst_pkg::weight_t weight_q;
	kumst_pkg::total_t  total_q;
	logic               acc_q;
	logic               out_valid_q;
	logic               out_acc_q;
	kumst_pkg::total_t  out_total_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [IDX_W-1:0] ram_rdata;
	logic             ram_ready;

	logic             in_beat;
	logic             in_range;
	logic             out_load;
	logic [IDX_W-1:0] idx_a;
	logic [IDX_W-1:0] idx_b;
	logic [kumst_pkg::TOTAL_W:0] sum;

	kumst_parent_ram #(
		.NODES(NODES)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata),
		.ready (ram_ready)
	);

	assign edge_in.ready = (state_q == ST_IDLE) && ram_ready;
	assign in_beat       = edge_in.valid && edge_in.ready;
	assign in_range      = (18'(edge_in.node_a) < NODES_L) && (18'(edge_in.node_b) < NODES_L);
	assign idx_a         = IDX_W'(edge_in.node_a);
	assign idx_b         = IDX_W'(edge_in.node_b);
	assign out_load      = (state_q == ST_OUT) && (!out_valid_q || result.ready);
	assign sum           = {1'b0, total_q} + (kumst_pkg::TOTAL_W + 1)'(weight_q);

	// memory port steering, one hop per cycle
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = x_q;
		ram_wdata = root_q;
		ram_raddr = idx_a;
		unique case (state_q)
			ST_IDLE: ram_raddr = idx_a;
			ST_WALK: begin
				if (ram_rdata == cur_q) begin
					ram_raddr = start_q;
				end else begin
					ram_raddr = ram_rdata;
				end
			end
			ST_COMP: begin
				if (x_q == root_q) begin
					ram_raddr = node_b_q;
					// union: second root points at the first
					if (phase_b_q && (root_a_q != root_q)) begin
						ram_we    = 1'b1;
						ram_waddr = root_q;
						ram_wdata = root_a_q;
					end
				end else begin
					ram_we    = 1'b1;
					ram_raddr = ram_rdata;
				end
			end
			ST_OUT: ram_raddr = idx_a;
			default: ram_raddr = idx_a;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_b_q <= 1'b0;
			total_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						phase_b_q <= 1'b0;
						state_q   <= in_range ? ST_WALK : ST_OUT;
					end
				end
				ST_WALK: begin
					if (ram_rdata == cur_q) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (x_q == root_q) begin
						if (!phase_b_q) begin
							phase_b_q <= 1'b1;
							state_q   <= ST_WALK;
						end else begin
							if (root_a_q != root_q) begin
								total_q <= sum[kumst_pkg::TOTAL_W] ? kumst_pkg::TOTAL_MAX
								                                   : sum[kumst_pkg::TOTAL_W-1:0];
							end
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk and compression datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					cur_q    <= idx_a;
					start_q  <= idx_a;
					node_b_q <= idx_b;
					weight_q <= edge_in.weight;
					acc_q    <= 1'b0;
				end
			end
			ST_WALK: begin
				if (ram_rdata == cur_q) begin
					root_q <= cur_q;
					x_q    <= start_q;
				end else begin
					cur_q <= ram_rdata;
				end
			end
			ST_COMP: begin
				if (x_q == root_q) begin
					if (!phase_b_q) begin
						root_a_q <= root_q;
						cur_q    <= node_b_q;
						start_q  <= node_b_q;
					end else begin
						acc_q <= (root_a_q != root_q);
					end
				end else begin
					x_q <= ram_rdata;
				end
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// output register, frees the input side while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_acc_q   <= acc_q;
			out_total_q <= total_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.accepted    = out_acc_q;
	assign result.tree_weight = out_total_q;

endmodule

// File: sv/kumst_checker.sv
// ----------------------------------------------------------------------------
// kumst_checker
// Port-level checks of the spanning tree accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module kumst_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              out_accepted,
	input kumst_pkg::total_t out_tree_weight
);

	kumst_pkg::total_t last_q;
	logic [1:0]        pending_q;

	logic in_beat;
	logic out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			pending_q <= '0;
		end else begin
			if (out_beat) begin
				last_q <= out_tree_weight;
			end
			if (in_beat && !out_beat) begin
				pending_q <= pending_q + 1'b1;
			end else if (!in_beat && out_beat) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	// a stalled result beat holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_tree_weight) && $stable(out_accepted))
		else $error("result payload changed while stalled");

	// the running total never falls
	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> out_tree_weight >= last_q)
		else $error("tree weight decreased");

	// a rejected edge leaves the total as it was
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !out_accepted |-> out_tree_weight == last_q)
		else $error("rejected edge changed the total");

	// at most one edge in work and one result waiting
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("too many edges outstanding");

	// no result without an edge behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without an edge");

endmodule

bind kruskal_union_find_mst kumst_checker u_kumst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (edge_in.valid),
	.in_ready       (edge_in.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_accepted   (result.accepted),
	.out_tree_weight(result.tree_weight)
);
